// ===== rtl/hsv2rgb_pkg.sv =====
// Package for the HSV to RGB converter: shared types, fixed constants and
// the hue split function. No dependencies.
package hsv2rgb_pkg;

    typedef logic [7:0]  t_chan;
    typedef logic [2:0]  t_sector;
    typedef logic [4:0]  t_frac;
    typedef logic [12:0] t_term;   // numerator factor, up to Denom
    typedef logic [20:0] t_prod;   // brightness times numerator factor

    typedef struct packed {
        t_sector sector;
        t_frac   frac;
    } t_hue_split;

    localparam logic [7:0]  HueWrap    = 8'd180;
    localparam logic [4:0]  SectorSpan = 5'd30;
    localparam logic [12:0] Denom      = 13'd7650;
    // floor(x / 7650) == (x * RecipMul) >> RecipShift for every x below 2**21.
    localparam logic [21:0] RecipMul   = 22'd2245735;
    localparam int          RecipShift = 34;
    localparam int          RecipWidth = 43;

    // Splits a hue code into its 60-degree sector and the remainder within it.
    // Codes past the circle count as hue zero.
    function automatic t_hue_split split_hue(input logic [7:0] hue);
        t_hue_split res;
        logic [7:0] base;
        res.sector = 3'd0;
        base       = 8'd0;
        if (hue >= HueWrap) begin
            res.sector = 3'd0;
            base       = hue;
        end else if (hue >= 8'd150) begin
            res.sector = 3'd5;
            base       = 8'd150;
        end else if (hue >= 8'd120) begin
            res.sector = 3'd4;
            base       = 8'd120;
        end else if (hue >= 8'd90) begin
            res.sector = 3'd3;
            base       = 8'd90;
        end else if (hue >= 8'd60) begin
            res.sector = 3'd2;
            base       = 8'd60;
        end else if (hue >= 8'd30) begin
            res.sector = 3'd1;
            base       = 8'd30;
        end
        res.frac = 5'(hue - base);
        return res;
    endfunction

endpackage

// ===== rtl/hsv2rgb_if.sv =====
// Handshake channel interfaces for the HSV to RGB converter.
// Depends on hsv2rgb_pkg for the payload types.
interface hsv2rgb_pix_if;
    logic                valid;
    logic                ready;
    hsv2rgb_pkg::t_chan  hue;
    hsv2rgb_pkg::t_chan  saturation;
    hsv2rgb_pkg::t_chan  brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

interface hsv2rgb_rgb_if;
    logic                valid;
    logic                ready;
    hsv2rgb_pkg::t_chan  red;
    hsv2rgb_pkg::t_chan  green;
    hsv2rgb_pkg::t_chan  blue;
    logic [15:0]         packed_565;

    modport source (output valid, output red, output green, output blue,
                    output packed_565, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input packed_565, output ready);
endinterface

// ===== rtl/hsv_to_rgb_converter_top.sv =====
// Five-stage HSV to RGB888/RGB565 converter.
// Depends on hsv2rgb_pkg and the channel interfaces in hsv2rgb_if.sv.
//
// Usage:
//   i_pix carries one HSV pixel per transaction (hue in 2-degree steps,
//   saturation and brightness as 8-bit codes). o_rgb returns one RGB
//   transaction per pixel, in order: red, green, blue and the RGB565 word.
//   Throughput is one pixel per cycle while the receiver is ready.
//   Stage 1 splits the hue into sector and remainder, stage 2 forms the
//   three numerator factors, stage 3 multiplies them by brightness,
//   stage 4 divides by 7650 through a reciprocal multiply, and stage 5
//   selects the channels per sector and packs the RGB565 word.
//   Each stage holds its own valid bit and moves whenever the stage after
//   it is empty or moving, so bubbles close up while the output waits.
//   When the receiver stalls, the output holds its transaction and the
//   pipeline keeps taking pixels until all five stages are full; then
//   i_pix.ready drops.
//   Reset (synchronous, active low) empties all stages; no output is
//   presented until new pixels arrive.
module hsv_to_rgb_converter_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    hsv2rgb_pix_if.sink          i_pix,
    hsv2rgb_rgb_if.source        o_rgb
);

    logic [5:1] r_vld;
    logic [5:1] en;

    // Stage 1 registers
    hsv2rgb_pkg::t_sector r1_sector;
    hsv2rgb_pkg::t_frac   r1_frac;
    hsv2rgb_pkg::t_chan   r1_sat;
    hsv2rgb_pkg::t_chan   r1_val;
    hsv2rgb_pkg::t_hue_split n1_split;

    // Stage 2 registers
    hsv2rgb_pkg::t_sector r2_sector;
    hsv2rgb_pkg::t_chan   r2_val;
    hsv2rgb_pkg::t_term   r2_ap, r2_aq, r2_at;
    hsv2rgb_pkg::t_term   n2_ap, n2_aq, n2_at;

    // Stage 3 registers
    hsv2rgb_pkg::t_sector r3_sector;
    hsv2rgb_pkg::t_chan   r3_val;
    hsv2rgb_pkg::t_prod   r3_pp, r3_pq, r3_pt;

    // Stage 4 registers
    hsv2rgb_pkg::t_sector r4_sector;
    hsv2rgb_pkg::t_chan   r4_val;
    hsv2rgb_pkg::t_chan   r4_p, r4_q, r4_t;
    logic [hsv2rgb_pkg::RecipWidth-1:0] n4_fp, n4_fq, n4_ft;

    // Stage 5 (output) registers
    hsv2rgb_pkg::t_chan   r5_red, r5_green, r5_blue;
    hsv2rgb_pkg::t_chan   n5_red, n5_green, n5_blue;

    // A stage advances when it is empty or the stage after it advances.
    always_comb begin
        en[5] = !r_vld[5] || o_rgb.ready;
        en[4] = !r_vld[4] || en[5];
        en[3] = !r_vld[3] || en[4];
        en[2] = !r_vld[2] || en[3];
        en[1] = !r_vld[1] || en[2];
    end

    assign i_pix.ready = en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) r_vld[1] <= i_pix.valid;
            if (en[2]) r_vld[2] <= r_vld[1];
            if (en[3]) r_vld[3] <= r_vld[2];
            if (en[4]) r_vld[4] <= r_vld[3];
            if (en[5]) r_vld[5] <= r_vld[4];
        end
    end

    // Stage 1: sector and remainder.
    assign n1_split = hsv2rgb_pkg::split_hue(i_pix.hue);

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_sector <= n1_split.sector;
            r1_frac   <= n1_split.frac;
            r1_sat    <= i_pix.saturation;
            r1_val    <= i_pix.brightness;
        end
    end

    // Stage 2: numerator factors Denom - 30*s, Denom - s*f, Denom - s*(30-f).
    always_comb begin
        n2_ap = hsv2rgb_pkg::Denom
              - 13'(13'(r1_sat) * 13'(hsv2rgb_pkg::SectorSpan));
        n2_aq = hsv2rgb_pkg::Denom - 13'(13'(r1_sat) * 13'(r1_frac));
        n2_at = hsv2rgb_pkg::Denom
              - 13'(13'(r1_sat) * 13'(hsv2rgb_pkg::SectorSpan - r1_frac));
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r2_sector <= r1_sector;
            r2_val    <= r1_val;
            r2_ap     <= n2_ap;
            r2_aq     <= n2_aq;
            r2_at     <= n2_at;
        end
    end

    // Stage 3: scale by brightness. Products stay below 255 * 7650 < 2**21.
    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r3_sector <= r2_sector;
            r3_val    <= r2_val;
            r3_pp     <= 21'(r2_val) * 21'(r2_ap);
            r3_pq     <= 21'(r2_val) * 21'(r2_aq);
            r3_pt     <= 21'(r2_val) * 21'(r2_at);
        end
    end

    // Stage 4: exact floor division by 7650 through the reciprocal constant.
    always_comb begin
        n4_fp = hsv2rgb_pkg::RecipWidth'(r3_pp) * hsv2rgb_pkg::RecipWidth'(hsv2rgb_pkg::RecipMul);
        n4_fq = hsv2rgb_pkg::RecipWidth'(r3_pq) * hsv2rgb_pkg::RecipWidth'(hsv2rgb_pkg::RecipMul);
        n4_ft = hsv2rgb_pkg::RecipWidth'(r3_pt) * hsv2rgb_pkg::RecipWidth'(hsv2rgb_pkg::RecipMul);
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r4_sector <= r3_sector;
            r4_val    <= r3_val;
            r4_p      <= n4_fp[hsv2rgb_pkg::RecipShift +: 8];
            r4_q      <= n4_fq[hsv2rgb_pkg::RecipShift +: 8];
            r4_t      <= n4_ft[hsv2rgb_pkg::RecipShift +: 8];
        end
    end

    // Stage 5: channel selection per sector. Zero saturation needs no special
    // case, since every term then equals the brightness.
    always_comb begin
        case (r4_sector)
            3'd0: begin
                n5_red = r4_val; n5_green = r4_t;   n5_blue = r4_p;
            end
            3'd1: begin
                n5_red = r4_q;   n5_green = r4_val; n5_blue = r4_p;
            end
            3'd2: begin
                n5_red = r4_p;   n5_green = r4_val; n5_blue = r4_t;
            end
            3'd3: begin
                n5_red = r4_p;   n5_green = r4_q;   n5_blue = r4_val;
            end
            3'd4: begin
                n5_red = r4_t;   n5_green = r4_p;   n5_blue = r4_val;
            end
            default: begin
                n5_red = r4_val; n5_green = r4_p;   n5_blue = r4_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r5_red   <= n5_red;
            r5_green <= n5_green;
            r5_blue  <= n5_blue;
        end
    end

    assign o_rgb.valid      = r_vld[5];
    assign o_rgb.red        = r5_red;
    assign o_rgb.green      = r5_green;
    assign o_rgb.blue       = r5_blue;
    assign o_rgb.packed_565 = {r5_red[7:3], r5_green[7:2], r5_blue[7:3]};

    // An accepted pixel always lands in the first stage.
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix.valid && i_pix.ready |=> r_vld[1])
        else $error("accepted pixel did not enter stage 1");

    // A waiting result is never dropped.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[5] && !o_rgb.ready |=> r_vld[5])
        else $error("stalled result was lost");

    // A full stage 4 moves into an empty output stage.
    a_bubble_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] && !r_vld[5] |=> r_vld[5])
        else $error("output stage stayed empty behind a full stage");

    // Input may only stall when every stage holds a pixel.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (r_vld == 5'b11111) && !o_rgb.ready)
        else $error("input stalled with room in the pipeline");

endmodule

// ===== sim/hsv_to_rgb_converter_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for hsv_to_rgb_converter_top: directed pixels, then random ones
// under varying handshake pressure. Depends on hsv2rgb_pkg and the channels in hsv2rgb_if.sv.
module hsv_to_rgb_converter_top_tb;

    typedef hsv2rgb_pkg::t_chan t_chan;

    localparam int unsigned HUE_CIRCLE     = 180;
    localparam int unsigned SECTOR_WIDTH   = 30;
    localparam int unsigned TERM_DENOM     = 7650;
    localparam int unsigned PHASE_ITEMS    = 500;
    localparam int unsigned HOLD_CYCLES    = 80;
    localparam int unsigned SETTLE_CYCLES  = 20;
    localparam int unsigned CYCLE_LIMIT    = 200000;
    localparam int          DIRECTED_COUNT = 24;

    typedef enum int unsigned {
        SECTOR_RED_YELLOW,
        SECTOR_YELLOW_GREEN,
        SECTOR_GREEN_CYAN,
        SECTOR_CYAN_BLUE,
        SECTOR_BLUE_MAGENTA,
        SECTOR_MAGENTA_RED
    } t_hue_sector;

    typedef struct packed {
        t_chan hue;
        t_chan sat;
        t_chan bri;
    } t_hsv_pixel;

    typedef struct packed {
        t_chan       red;
        t_chan       green;
        t_chan       blue;
        logic [15:0] packed_565;
    } t_rgb_pixel;

    typedef struct packed {
        t_chan hue;
        t_chan sat;
        t_chan bri;
        logic  known;
        t_chan red;
        t_chan green;
        t_chan blue;
    } t_directed_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;
    int unsigned sink_hold_req;
    int unsigned mismatch_count;
    int unsigned cycle_count;
    t_rgb_pixel  rgb_expected_q[$];

    hsv2rgb_pix_if pix_if ();
    hsv2rgb_rgb_if rgb_if ();

    hsv_to_rgb_converter_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if.sink),
        .o_rgb   (rgb_if.source)
    );

    always #5 i_clk = ~i_clk;

    // Hue, saturation, brightness, then the expected channels where they are obvious.
    t_directed_row directed_rows [DIRECTED_COUNT] = '{
        '{8'd0,   8'd0,   8'd0,   1'b1, 8'd0,   8'd0,   8'd0},
        '{8'd255, 8'd0,   8'd255, 1'b1, 8'd255, 8'd255, 8'd255},
        '{8'd100, 8'd0,   8'd77,  1'b1, 8'd77,  8'd77,  8'd77},
        '{8'd0,   8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0},
        '{8'd30,  8'd255, 8'd255, 1'b1, 8'd255, 8'd255, 8'd0},
        '{8'd60,  8'd255, 8'd255, 1'b1, 8'd0,   8'd255, 8'd0},
        '{8'd90,  8'd255, 8'd255, 1'b1, 8'd0,   8'd255, 8'd255},
        '{8'd120, 8'd255, 8'd255, 1'b1, 8'd0,   8'd0,   8'd255},
        '{8'd150, 8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd255},
        '{8'd180, 8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0},
        '{8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0},
        '{8'd15,  8'd255, 8'd0,   1'b1, 8'd0,   8'd0,   8'd0},
        '{8'd200, 8'd128, 8'd99,  1'b0, 8'd0,   8'd0,   8'd0},
        '{8'd179, 8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
        '{8'd29,  8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
        '{8'd59,  8'd200, 8'd180, 1'b0, 8'd0,   8'd0,   8'd0},
        '{8'd89,  8'd1,   8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
        '{8'd119, 8'd254, 8'd254, 1'b0, 8'd0,   8'd0,   8'd0},
        '{8'd149, 8'd128, 8'd128, 1'b0, 8'd0,   8'd0,   8'd0},
        '{8'd75,  8'd255, 8'd1,   1'b0, 8'd0,   8'd0,   8'd0},
        '{8'd165, 8'd170, 8'd85,  1'b0, 8'd0,   8'd0,   8'd0},
        '{8'd45,  8'd85,  8'd170, 1'b0, 8'd0,   8'd0,   8'd0},
        '{8'd135, 8'd1,   8'd1,   1'b0, 8'd0,   8'd0,   8'd0},
        '{8'd170, 8'd255, 8'd128, 1'b0, 8'd0,   8'd0,   8'd0}
    };

    function automatic logic [15:0] pack_565(input t_chan r, input t_chan g, input t_chan b);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    function automatic int unsigned scaled_term(input int unsigned v, input int unsigned cut);
        return (v * (TERM_DENOM - cut)) / TERM_DENOM;
    endfunction

    function automatic t_rgb_pixel convert_pixel(input t_hsv_pixel px);
        t_rgb_pixel  res;
        t_hue_sector sector;
        int unsigned hue_code, frac, v, s, p, q, t, r, g, b;
        hue_code = (32'(px.hue) >= HUE_CIRCLE) ? 32'd0 : 32'(px.hue);
        v        = 32'(px.bri);
        s        = 32'(px.sat);
        sector   = t_hue_sector'(hue_code / SECTOR_WIDTH);
        frac     = hue_code % SECTOR_WIDTH;
        p        = scaled_term(v, s * SECTOR_WIDTH);
        q        = scaled_term(v, s * frac);
        t        = scaled_term(v, s * (SECTOR_WIDTH - frac));
        if (s == 0) begin
            r = v;
            g = v;
            b = v;
        end else begin
            case (sector)
                SECTOR_RED_YELLOW:   begin r = v; g = t; b = p; end
                SECTOR_YELLOW_GREEN: begin r = q; g = v; b = p; end
                SECTOR_GREEN_CYAN:   begin r = p; g = v; b = t; end
                SECTOR_CYAN_BLUE:    begin r = p; g = q; b = v; end
                SECTOR_BLUE_MAGENTA: begin r = t; g = p; b = v; end
                default:             begin r = v; g = p; b = q; end
            endcase
        end
        res.red        = 8'(r);
        res.green      = 8'(g);
        res.blue       = 8'(b);
        res.packed_565 = pack_565(res.red, res.green, res.blue);
        return res;
    endfunction

    function automatic t_chan corner_code();
        case ($urandom_range(3))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd254;
            default: return 8'd255;
        endcase
    endfunction

    // Mostly plain colors, with gray, wrapped hue and sector corners mixed in.
    function automatic t_hsv_pixel random_pixel();
        t_hsv_pixel  px;
        int unsigned pick;
        pick   = $urandom_range(99);
        px.hue = 8'($urandom_range(HUE_CIRCLE - 1));
        px.sat = 8'($urandom_range(255));
        px.bri = 8'($urandom_range(255));
        if (pick < 10) begin
            px.sat = 8'd0;
        end else if (pick < 20) begin
            px.hue = 8'($urandom_range(255, HUE_CIRCLE));
        end else if (pick < 32) begin
            px.hue = 8'($urandom_range(5) * SECTOR_WIDTH + ($urandom_range(1) ? 29 : 0));
            px.sat = corner_code();
            px.bri = corner_code();
        end else if (pick < 40) begin
            px.hue = 8'($urandom_range(255));
        end
        return px;
    endfunction

    task automatic send_pixel(input t_hsv_pixel px, input t_rgb_pixel want);
        while ($urandom_range(99) < src_idle_pct) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_if.valid      <= 1'b1;
        pix_if.hue        <= px.hue;
        pix_if.saturation <= px.sat;
        pix_if.brightness <= px.bri;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        rgb_expected_q.push_back(want);
    endtask

    task automatic wait_for_drain();
        while (rgb_expected_q.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: random back-pressure, plus long hold-offs on request.
    initial begin : sink_side
        int unsigned hold_left;
        hold_left    = 0;
        rgb_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold_req != 0) begin
                hold_left     = sink_hold_req;
                sink_hold_req = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                rgb_if.ready <= 1'b0;
            end else begin
                rgb_if.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rgb_if.valid && rgb_if.ready) begin
            if (rgb_expected_q.size() == 0) begin
                $error("unexpected RGB transaction: red %0d green %0d blue %0d",
                       rgb_if.red, rgb_if.green, rgb_if.blue);
                mismatch_count++;
            end else begin
                t_rgb_pixel want;
                want = rgb_expected_q.pop_front();
                if (rgb_if.red !== want.red) begin
                    $error("red: expected %0d, got %0d", want.red, rgb_if.red);
                    mismatch_count++;
                end
                if (rgb_if.green !== want.green) begin
                    $error("green: expected %0d, got %0d", want.green, rgb_if.green);
                    mismatch_count++;
                end
                if (rgb_if.blue !== want.blue) begin
                    $error("blue: expected %0d, got %0d", want.blue, rgb_if.blue);
                    mismatch_count++;
                end
                if (rgb_if.packed_565 !== want.packed_565) begin
                    $error("packed_565: expected 0x%04h, got 0x%04h",
                           want.packed_565, rgb_if.packed_565);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("hsv_to_rgb_converter_top_tb NOT OK");
        $finish;
    end

    initial begin : stimulus
        t_directed_row row;
        t_hsv_pixel    px;
        t_rgb_pixel    want;
        i_rst_n           = 1'b0;
        pix_if.valid      = 1'b0;
        pix_if.hue        = '0;
        pix_if.saturation = '0;
        pix_if.brightness = '0;
        src_idle_pct      = 0;
        sink_idle_pct     = 0;
        sink_hold_req     = 0;
        mismatch_count    = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIRECTED_COUNT; i++) begin
            row    = directed_rows[i];
            px.hue = row.hue;
            px.sat = row.sat;
            px.bri = row.bri;
            want   = convert_pixel(px);
            if (row.known) begin
                want.red        = row.red;
                want.green      = row.green;
                want.blue       = row.blue;
                want.packed_565 = pack_565(row.red, row.green, row.blue);
            end
            send_pixel(px, want);
        end

        // Three random phases: receiver-heavy gaps, sender-heavy gaps, then full rate.
        for (int phase = 0; phase < 3; phase++) begin
            pix_if.valid <= 1'b0;
            wait_for_drain();
            case (phase)
                0:       begin src_idle_pct = 33; sink_idle_pct = 64; end
                1:       begin src_idle_pct = 64; sink_idle_pct = 33; end
                default: begin src_idle_pct = 0;  sink_idle_pct = 0;  end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // A long receiver hold-off mid-phase lets the pipeline fill and stall.
                if (n == PHASE_ITEMS / 2) sink_hold_req = HOLD_CYCLES;
                px = random_pixel();
                send_pixel(px, convert_pixel(px));
            end
        end

        pix_if.valid <= 1'b0;
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("hsv_to_rgb_converter_top_tb OK");
        end else begin
            $display("hsv_to_rgb_converter_top_tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/hsv2rgb_pkg.sv
rtl/hsv2rgb_if.sv
rtl/hsv_to_rgb_converter_top.sv
sim/hsv_to_rgb_converter_top_tb.sv
